@@ rtl/core/sdpg_pkg.sv @@
// Shared types and constants for the step/direction pulse generator.
// Used by sdpg_engine and step_dir_pulse_generator_unit; no dependencies.
package sdpg_pkg;

    // Pin groups and masks are five bits wide at the ports
    localparam int PIN_BITS      = 5;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_INVERT    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIR_INVERT     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PULSE_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIR_STEP_DELAY = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY_ENABLE   = 3'd4;

    // Reset values of the timing registers
    localparam logic [CFG_DATA_BITS-1:0] PULSE_WIDTH_RESET    = 16'd2;
    localparam logic [CFG_DATA_BITS-1:0] DIR_STEP_DELAY_RESET = 16'd2;

    typedef logic [PIN_BITS-1:0] pins_t;

    // Operation codes; code 3 is unused and ignored
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_STEP = 2'd1,
        OP_IDLE = 2'd2
    } op_t;

    typedef struct packed {
        op_t   operation;
        pins_t step_bits;
        pins_t dir_bits;
        logic  dir_turned;
    } sdpg_in_t;

    typedef struct packed {
        pins_t step_pins;
        pins_t dir_pin_lvl;
        logic  busy_res;
    } sdpg_out_t;

    typedef struct packed {
        pins_t                    step_inv_mask;
        pins_t                    dir_inv_mask;
        logic [CFG_DATA_BITS-1:0] pulse_width;
        logic [CFG_DATA_BITS-1:0] dir_step_delay;
        logic                     delay_enable;
    } sdpg_cfg_t;

endpackage

@@ rtl/core/sdpg_engine.sv @@
// Pin and countdown state of the pulse generator, and the update for one transaction.
// Depends on sdpg_pkg.
module sdpg_engine #(
    parameter int AXES       = 5,
    parameter int COUNT_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                apply,
    input  sdpg_pkg::sdpg_cfg_t cfg,
    input  sdpg_pkg::sdpg_in_t  item,
    output sdpg_pkg::sdpg_out_t result
);
    import sdpg_pkg::*;

    // Axes beyond AXES are always driven low
    localparam pins_t AXIS_MASK = PIN_BITS'((64'd1 << AXES) - 64'd1);

    typedef logic [COUNT_BITS-1:0] count_t;

    pins_t  step_level_reg, step_level_next;
    pins_t  dir_level_reg, dir_level_next;
    pins_t  pending_reg, pending_next;
    count_t count_reg, count_next;
    logic   running_reg, running_next;

    count_t pulse_load;
    count_t delay_load;

    assign pulse_load = COUNT_BITS'(cfg.pulse_width);
    assign delay_load = COUNT_BITS'(cfg.dir_step_delay);

    // Apply one operation to the current state
    always_comb begin
        step_level_next = step_level_reg;
        dir_level_next  = dir_level_reg;
        pending_next    = pending_reg;
        count_next      = count_reg;
        running_next    = running_reg;
        unique case (item.operation)
            OP_TICK: begin
                if (running_reg) begin
                    if (count_reg > count_t'(1)) begin
                        count_next = count_reg - count_t'(1);
                    end else if (pending_reg != '0) begin
                        // delay over: fire the held steps and time their pulse
                        step_level_next = (pending_reg ^ cfg.step_inv_mask) & AXIS_MASK;
                        pending_next    = '0;
                        count_next      = pulse_load;
                    end else begin
                        // pulse over: return step pins to idle
                        step_level_next = cfg.step_inv_mask & AXIS_MASK;
                        count_next      = '0;
                        running_next    = 1'b0;
                    end
                end
            end
            OP_STEP: begin
                if (item.dir_turned) begin
                    dir_level_next = (item.dir_bits ^ cfg.dir_inv_mask) & AXIS_MASK;
                end
                if (item.dir_turned && cfg.delay_enable) begin
                    // hold the steps until the direction has settled
                    if (item.step_bits != '0) begin
                        pending_next = item.step_bits & AXIS_MASK;
                        if (!running_reg) begin
                            count_next   = delay_load;
                            running_next = 1'b1;
                        end
                    end
                end else if (item.step_bits != '0) begin
                    step_level_next = (item.step_bits ^ cfg.step_inv_mask) & AXIS_MASK;
                    if (!running_reg) begin
                        count_next   = pulse_load;
                        running_next = 1'b1;
                    end
                end
            end
            OP_IDLE: begin
                step_level_next = cfg.step_inv_mask & AXIS_MASK;
                dir_level_next  = cfg.dir_inv_mask & AXIS_MASK;
            end
            default: begin
            end
        endcase
    end

    // Hold state; advance only on an applied transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_level_reg <= '0;
            dir_level_reg  <= '0;
            pending_reg    <= '0;
            count_reg      <= '0;
            running_reg    <= 1'b0;
        end else if (apply) begin
            step_level_reg <= step_level_next;
            dir_level_reg  <= dir_level_next;
            pending_reg    <= pending_next;
            count_reg      <= count_next;
            running_reg    <= running_next;
        end
    end

    // Report the state after the operation
    assign result.step_pins   = step_level_next;
    assign result.dir_pin_lvl = dir_level_next;
    assign result.busy_res    = running_next;

endmodule

@@ rtl/core/step_dir_pulse_generator_unit.sv @@
// Top level of the step/direction pulse generator: input and result registers,
// configuration registers. Depends on sdpg_pkg and sdpg_engine.
//
// Usage:
//   s_valid/s_ready/s_data carry transactions: tick, step command or go idle.
//   m_valid/m_ready/m_data return one result per transaction: step pin levels,
//   direction pin levels and the busy flag after that transaction is applied.
//   cfg_wr_en/cfg_wr_index/cfg_wr_data write the inversion masks, pulse width,
//   direction-to-step delay and delay enable; write only while the block is idle.
// Path: the input register takes the transaction, then the result register loads
//   the engine's result when it is empty or its result is being taken, and
//   m_valid rises with that load.
// Throughput: one transaction per cycle while m_ready is high; the state update
//   is a single pass of logic between the input and result registers.
// Reset: pins, pending steps and countdown clear; inversion masks clear,
//   pulse width and delay return to two ticks, delayed mode off.
// Stall: while m_ready is low the result holds; the input register still takes
//   one more transaction, after which s_ready drops until the result is taken.
module step_dir_pulse_generator_unit #(
    parameter int AXES       = 5,
    parameter int COUNT_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  sdpg_pkg::sdpg_in_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output sdpg_pkg::sdpg_out_t                   m_data,
    input  logic                                  cfg_wr_en,
    input  logic [sdpg_pkg::CFG_IDX_BITS-1:0]     cfg_wr_index,
    input  logic [sdpg_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data
);
    import sdpg_pkg::*;

    sdpg_cfg_t cfg_reg;
    sdpg_in_t  in_data_reg;
    logic      in_valid_reg;
    sdpg_out_t out_data_reg;
    logic      out_valid_reg;
    sdpg_out_t result;
    logic      advance;

    // Move a transaction from the input register into the result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_inv_mask  <= '0;
            cfg_reg.dir_inv_mask   <= '0;
            cfg_reg.pulse_width    <= PULSE_WIDTH_RESET;
            cfg_reg.dir_step_delay <= DIR_STEP_DELAY_RESET;
            cfg_reg.delay_enable   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_STEP_INVERT:    cfg_reg.step_inv_mask  <= cfg_wr_data[PIN_BITS-1:0];
                CFG_DIR_INVERT:     cfg_reg.dir_inv_mask   <= cfg_wr_data[PIN_BITS-1:0];
                CFG_PULSE_WIDTH:    cfg_reg.pulse_width    <= cfg_wr_data;
                CFG_DIR_STEP_DELAY: cfg_reg.dir_step_delay <= cfg_wr_data;
                CFG_DELAY_ENABLE:   cfg_reg.delay_enable   <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    sdpg_engine #(
        .AXES       (AXES),
        .COUNT_BITS (COUNT_BITS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .apply   (advance),
        .cfg     (cfg_reg),
        .item    (in_data_reg),
        .result  (result)
    );

    // Result register: load on advance, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
